// ----- rtl/urlpe_pkg.sv -----
// urlpe_pkg: types, constants and helpers of the URL percent encoder.
// No dependencies; used by the interfaces, the mask bank and the top level.
`default_nettype none

package urlpe_pkg;

  // Encode mask geometry: eight 32-bit words cover byte values 0..255
  localparam int MASK_WORDS    = 8;
  localparam int MASK_BITS     = 32;
  localparam int CFG_IDX_BITS  = 4;
  localparam int BYTE_BITS     = 8;
  localparam int OUT_CNT_BITS  = 16;

  typedef logic [MASK_BITS-1:0] mask_word_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  // Reset contents: controls, space and URL-reserved characters plus all high bytes
  localparam mask_word_t MASK_RESET [MASK_WORDS] = '{
    32'hFFFF_FFFF, 32'hFC00_987B, 32'h7800_0001, 32'hF800_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  localparam byte_t PCT_CHAR = 8'h25;

  // Which result of an encoded byte is being emitted
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_HI    = 2'd1,
    PH_LO    = 2'd2
  } phase_t;

  // Upper-case ASCII hex digit of one nibble
  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/urlpe_if.sv -----
// urlpe_in_if / urlpe_out_if: valid/ready channels of the URL percent encoder.
// Depend on urlpe_pkg for the payload widths.
`default_nettype none

interface urlpe_in_if;
  logic                 valid;
  logic                 ready;
  urlpe_pkg::byte_t     in_byte;
  logic                 string_end;

  modport source (output valid, in_byte, string_end, input ready);
  modport sink   (input valid, in_byte, string_end, output ready);
endinterface

interface urlpe_out_if;
  logic                                  valid;
  logic                                  ready;
  urlpe_pkg::byte_t                      out_byte;
  logic                                  run_last;
  logic                                  string_last;
  logic [urlpe_pkg::OUT_CNT_BITS-1:0]    out_count;

  modport source (output valid, out_byte, run_last, string_last, out_count, input ready);
  modport sink   (input valid, out_byte, run_last, string_last, out_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/urlpe_mask.sv -----
// urlpe_mask: the eight 32-bit encode mask registers and the per-byte lookup.
// Depends on urlpe_pkg.
`default_nettype none

module urlpe_mask (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [urlpe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [urlpe_pkg::MASK_BITS-1:0]    cfg_wdata,
  input  wire urlpe_pkg::byte_t                   lookup_byte,
  output logic                                    lookup_enc
);

  urlpe_pkg::mask_word_t mask_r [urlpe_pkg::MASK_WORDS];
  logic [urlpe_pkg::MASK_WORDS*urlpe_pkg::MASK_BITS-1:0] mask_flat;

  // Write one word; indexes past the bank are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < urlpe_pkg::MASK_WORDS; k++) begin
        mask_r[k] <= urlpe_pkg::MASK_RESET[k];
      end
    end else if (cfg_we && (cfg_index < urlpe_pkg::CFG_IDX_BITS'(urlpe_pkg::MASK_WORDS))) begin
      mask_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // Flatten so bit b of the vector is the flag of byte value b
  always_comb begin
    for (int k = 0; k < urlpe_pkg::MASK_WORDS; k++) begin
      mask_flat[k*urlpe_pkg::MASK_BITS +: urlpe_pkg::MASK_BITS] = mask_r[k];
    end
  end

  assign lookup_enc = mask_flat[lookup_byte];

endmodule

`default_nettype wire

// ----- rtl/url_percent_encoder.sv -----
// url_percent_encoder: top level; percent-encodes a byte stream against a 256-bit mask.
// Depends on urlpe_pkg, urlpe_in_if / urlpe_out_if and urlpe_mask.
//
//   channel   dir   beat contents
//   in_chan   in    in_byte[7:0], string_end
//   out_chan  out   out_byte[7:0], run_last, string_last, out_count[15:0]
//   cfg_*     in    cfg_we, cfg_index[3:0], cfg_wdata[31:0] (write only)
//
// One result beat per cycle unless out_chan stalls: a passed-through byte gives one
// result, an encoded byte three, all through the single output register.
// The byte register takes the next beat in the cycle its last result is loaded.
// Reset is synchronous: the mask returns to its default and the count to zero.
// A stall on out_chan holds the output register and, once the byte register is
// full, drops in_chan.ready; no beat is lost.
`default_nettype none

module url_percent_encoder #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  urlpe_in_if.sink                                in_chan,
  urlpe_out_if.source                             out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [urlpe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [urlpe_pkg::MASK_BITS-1:0]    cfg_wdata
);

  localparam int CNT_W = (COUNT_BITS > urlpe_pkg::OUT_CNT_BITS) ?
                         COUNT_BITS : urlpe_pkg::OUT_CNT_BITS;

  // Byte register
  logic                  item_vld_r;
  urlpe_pkg::byte_t      item_byte_r;
  logic                  item_last_r;
  logic                  item_enc_r;
  urlpe_pkg::phase_t     phase_r, phase_nxt;

  // Output register
  logic                  out_vld_r;
  urlpe_pkg::byte_t      out_byte_r;
  logic                  run_last_r;
  logic                  string_last_r;
  logic [urlpe_pkg::OUT_CNT_BITS-1:0] out_count_r;

  logic [COUNT_BITS-1:0] count_r, count_nxt, cnt_inc;
  logic [CNT_W-1:0]      cnt_wide;

  logic                  lookup_enc;
  logic                  out_adv;
  logic                  step;
  logic                  res_final;
  urlpe_pkg::byte_t      res_byte;
  logic                  in_acc;

  urlpe_mask u_mask (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .lookup_byte (in_chan.in_byte),
    .lookup_enc  (lookup_enc)
  );

  // Handshake
  assign out_adv        = !out_vld_r || out_chan.ready;
  assign step           = item_vld_r && out_adv;
  assign res_final      = !item_enc_r || (phase_r == urlpe_pkg::PH_LO);
  assign in_chan.ready  = !item_vld_r || (step && res_final);
  assign in_acc         = in_chan.valid && in_chan.ready;

  // Select the result byte for the current phase
  always_comb begin
    case (phase_r)
      urlpe_pkg::PH_FIRST: res_byte = item_enc_r ? urlpe_pkg::PCT_CHAR : item_byte_r;
      urlpe_pkg::PH_HI:    res_byte = urlpe_pkg::hex_digit(item_byte_r[7:4]);
      urlpe_pkg::PH_LO:    res_byte = urlpe_pkg::hex_digit(item_byte_r[3:0]);
      default:             res_byte = item_byte_r;
    endcase
  end

  // Advance the phase
  always_comb begin
    case (phase_r)
      urlpe_pkg::PH_FIRST: phase_nxt = urlpe_pkg::PH_HI;
      urlpe_pkg::PH_HI:    phase_nxt = urlpe_pkg::PH_LO;
      default:             phase_nxt = urlpe_pkg::PH_FIRST;
    endcase
  end

  // Saturating count; clear after the string's last result
  assign cnt_inc   = (count_r == {COUNT_BITS{1'b1}}) ? count_r : count_r + COUNT_BITS'(1);
  assign cnt_wide  = CNT_W'(cnt_inc);
  assign count_nxt = (res_final && item_last_r) ? '0 : cnt_inc;

  // Byte register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      phase_r    <= urlpe_pkg::PH_FIRST;
      count_r    <= '0;
    end else begin
      if (in_acc) begin
        item_vld_r <= 1'b1;
        phase_r    <= urlpe_pkg::PH_FIRST;
      end else if (step && res_final) begin
        item_vld_r <= 1'b0;
        phase_r    <= urlpe_pkg::PH_FIRST;
      end else if (step) begin
        phase_r    <= phase_nxt;
      end
      if (step) begin
        count_r <= count_nxt;
      end
    end
  end

  // Byte register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_byte_r <= in_chan.in_byte;
      item_last_r <= in_chan.string_end;
      item_enc_r  <= lookup_enc;
    end
  end

  // Output register valid: load on a step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r    <= res_byte;
      run_last_r    <= res_final;
      string_last_r <= res_final && item_last_r;
      out_count_r   <= cnt_wide[urlpe_pkg::OUT_CNT_BITS-1:0];
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.run_last    = run_last_r;
  assign out_chan.string_last = string_last_r;
  assign out_chan.out_count   = out_count_r;

  // Checks
  a_strlast_is_runlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && string_last_r |-> run_last_r)
    else $error("string_last without run_last");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_final && item_last_r |=> count_r == '0)
    else $error("count not cleared after end of string");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !item_enc_r |-> phase_r == urlpe_pkg::PH_FIRST)
    else $error("pass-through byte left its first phase");

  a_no_accept_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !(step && res_final) |-> !in_chan.ready)
    else $error("input taken while a byte is still expanding");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for url_percent_encoder (directed rows, random strings,
// a long full-rate string). Depends on urlpe_pkg, urlpe_in_if / urlpe_out_if and the RTL.

module testbench;

  localparam int CNT_W        = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int RUN_BEATS    = 40;
  localparam int N_DIRECTED   = 30;
  localparam int N_CORNERS    = 8;
  localparam int MAX_REPORTS  = 10;
  localparam urlpe_pkg::byte_t PERCENT = 8'h25;

  // Register indexes of the write port
  typedef enum logic [3:0] {
    REG_MASK_0   = 4'd0,
    REG_MASK_1   = 4'd1,
    REG_MASK_2   = 4'd2,
    REG_MASK_3   = 4'd3,
    REG_MASK_4   = 4'd4,
    REG_MASK_5   = 4'd5,
    REG_MASK_6   = 4'd6,
    REG_MASK_7   = 4'd7,
    REG_SPARE_8  = 4'd8,
    REG_SPARE_15 = 4'd15
  } reg_idx_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_REG
  } row_kind_t;

  // One directed row: a beat (with optional typed output bytes) or a register write
  typedef struct packed {
    row_kind_t             kind;
    urlpe_pkg::byte_t      val;
    logic                  fin;
    logic [1:0]            n_typed;
    logic [23:0]           typed;
    logic [3:0]            idx;
    urlpe_pkg::mask_word_t wdata;
  } step_row_t;

  typedef struct packed {
    urlpe_pkg::byte_t                   out_byte;
    logic                               run_last;
    logic                               string_last;
    logic [urlpe_pkg::OUT_CNT_BITS-1:0] out_count;
  } result_t;

  localparam urlpe_pkg::mask_word_t URL_MASK [urlpe_pkg::MASK_WORDS] = '{
    32'hFFFF_FFFF, 32'hFC00_987B, 32'h7800_0001, 32'hF800_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  localparam urlpe_pkg::byte_t CORNER_BYTES [N_CORNERS] = '{
    8'h00, 8'hFF, 8'h7F, 8'h80, 8'h1F, 8'h20, 8'h25, 8'hE0
  };

  // Directed rows: typed bytes where the mask in force makes them obvious
  localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_BEAT, 8'h00, 1'b0, 2'd3, "%00",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h41, 1'b0, 2'd1, "A",    REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h2D, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h20, 1'b0, 2'd3, "%20",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h7E, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h7F, 1'b0, 2'd3, "%7F",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h80, 1'b0, 2'd3, "%80",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h5B, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h61, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h30, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'hFF, 1'b1, 2'd3, "%FF",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h78, 1'b1, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h0A, 1'b1, 2'd3, "%0A",  REG_MASK_0,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_1,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_2,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_3,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_4,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_5,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_6,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_7,   32'h0},
    '{ROW_BEAT, 8'h00, 1'b0, 2'd1, 24'h0,  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h25, 1'b0, 2'd1, "%",    REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'hFF, 1'b1, 2'd1, 24'hFF, REG_MASK_0,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_SPARE_8,  32'hFFFF_FFFF},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_SPARE_15, 32'hFFFF_FFFF},
    '{ROW_BEAT, 8'h41, 1'b0, 2'd1, "A",    REG_MASK_0,   32'h0},
    '{ROW_REG,  8'h00, 1'b0, 2'd0, 24'h0,  REG_MASK_2,   32'h0000_0002},
    '{ROW_BEAT, 8'h41, 1'b0, 2'd3, "%41",  REG_MASK_0,   32'h0},
    '{ROW_BEAT, 8'h42, 1'b1, 2'd0, 24'h0,  REG_MASK_0,   32'h0}
  };

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [urlpe_pkg::CFG_IDX_BITS-1:0] cfg_index;
  urlpe_pkg::mask_word_t              cfg_wdata;

  urlpe_in_if  in_ch ();
  urlpe_out_if out_ch ();

  url_percent_encoder #(
    .COUNT_BITS (CNT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the encoder: mask bank and per-string emit count
  urlpe_pkg::mask_word_t enc_mask [urlpe_pkg::MASK_WORDS];
  logic [CNT_W-1:0]      emitted;
  result_t               pending_results [$];

  logic idle_on;
  logic pressure_go;
  logic hold_ready;
  int   fault_count;
  int   beats_sent;
  int   strings_sent;
  int   beats_checked;
  int   mask_settings;
  int   cycle_count;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("[%0t] FAULT: %s", $time, what);
    end
  endfunction

  function automatic urlpe_pkg::byte_t ascii_hex(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
  endfunction

  // Output bytes of one input byte, first emitted byte in the highest used slot
  function automatic logic [23:0] encoded_form(input urlpe_pkg::byte_t b, output int n);
    if (enc_mask[b[7:5]][b[4:0]]) begin
      n = 3;
      return {PERCENT, ascii_hex(b[7:4]), ascii_hex(b[3:0])};
    end
    n = 1;
    return {16'h0, b};
  endfunction

  // Queue the results of one accepted byte and advance the emit count
  function automatic void push_results(input logic [23:0] seq, input int n, input logic fin);
    result_t r;
    for (int k = 0; k < n; k++) begin
      if (emitted != {CNT_W{1'b1}}) emitted++;
      r.out_byte    = seq[8*(n-1-k) +: 8];
      r.run_last    = (k == n - 1);
      r.string_last = (k == n - 1) && fin;
      r.out_count   = urlpe_pkg::OUT_CNT_BITS'(emitted);
      pending_results.push_back(r);
    end
    if (fin) emitted = '0;
  endfunction

  function automatic urlpe_pkg::byte_t pick_byte();
    if ($urandom_range(3) == 0) return CORNER_BYTES[$urandom_range(N_CORNERS - 1)];
    return urlpe_pkg::byte_t'($urandom_range(255));
  endfunction

  // Offer one beat, with random gaps, and queue its results once accepted
  task automatic send_beat(input urlpe_pkg::byte_t b, input logic fin, input int n_typed,
                           input logic [23:0] typed);
    logic [23:0] seq;
    int          n;
    while (idle_on && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.string_end <= fin;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    seq = encoded_form(b, n);
    if (n_typed != 0) begin
      seq = typed;
      n   = n_typed;
    end
    push_results(seq, n, fin);
    beats_sent++;
    if (fin) strings_sent++;
  endtask

  // Drop valid and hold until every queued result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_we after the last write of a batch
  task automatic write_reg(input logic [urlpe_pkg::CFG_IDX_BITS-1:0] idx,
                           input urlpe_pkg::mask_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= REG_MASK_7) enc_mask[idx[2:0]] = val;
  endtask

  task automatic load_masks(input urlpe_pkg::mask_word_t words [urlpe_pkg::MASK_WORDS]);
    wait_drained();
    for (int k = 0; k < urlpe_pkg::MASK_WORDS; k++) begin
      write_reg(urlpe_pkg::CFG_IDX_BITS'(REG_MASK_0 + k), words[k]);
    end
    // a write to an unused index must leave the mask alone
    write_reg(urlpe_pkg::CFG_IDX_BITS'($urandom_range(REG_SPARE_15, REG_SPARE_8)),
              $urandom());
    cfg_we <= 1'b0;
    mask_settings++;
  endtask

  task automatic run_strings(input urlpe_pkg::mask_word_t words [urlpe_pkg::MASK_WORDS],
                             input int n_items, input int pressure_at);
    load_masks(words);
    for (int i = 0; i < n_items; i++) begin
      if (i == pressure_at) pressure_go = 1'b1;
      send_beat(pick_byte(), $urandom_range(7) == 0, 0, 24'h0);
    end
  endtask

  // Receiver: random stalls, none while idling is off, a long hold on request
  always @(posedge clk) begin
    if (hold_ready) begin
      out_ch.ready <= 1'b0;
    end else if (idle_on) begin
      out_ch.ready <= ($urandom_range(99) >= 27);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hold off the receiver once so the encoder backs up into its input
  initial begin
    hold_ready = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_ready <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_ready <= 1'b0;
  end

  // Compare each accepted output beat with the oldest queued result
  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("output beat %02h with nothing queued", out_ch.out_byte));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          note_fault($sformatf("beat %0d out_byte: expected %02h, got %02h",
                               beats_checked, want.out_byte, out_ch.out_byte));
        if (out_ch.run_last !== want.run_last)
          note_fault($sformatf("beat %0d run_last: expected %b, got %b",
                               beats_checked, want.run_last, out_ch.run_last));
        if (out_ch.string_last !== want.string_last)
          note_fault($sformatf("beat %0d string_last: expected %b, got %b",
                               beats_checked, want.string_last, out_ch.string_last));
        if (out_ch.out_count !== want.out_count)
          note_fault($sformatf("beat %0d out_count: expected %0d, got %0d",
                               beats_checked, want.out_count, out_ch.out_count));
      end
      beats_checked++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    urlpe_pkg::mask_word_t words [urlpe_pkg::MASK_WORDS];

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.string_end = 1'b0;
    out_ch.ready     = 1'b0;
    idle_on          = 1'b1;
    pressure_go      = 1'b0;
    fault_count      = 0;
    beats_sent       = 0;
    strings_sent     = 0;
    beats_checked    = 0;
    mask_settings    = 0;
    enc_mask         = URL_MASK;
    emitted          = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows under the reset mask, then cleared and single-bit masks
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].wdata);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_beat(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].fin,
                  DIRECTED_ROWS[i].n_typed, DIRECTED_ROWS[i].typed);
      end
    end

    // Random strings over several mask settings, extremes included
    run_strings(URL_MASK, 100, -1);
    foreach (words[k]) words[k] = '1;
    run_strings(words, 100, 40);
    foreach (words[k]) words[k] = $urandom();
    run_strings(words, 80, -1);
    foreach (words[k]) words[k] = '0;
    run_strings(words, 50, -1);
    foreach (words[k]) words[k] = $urandom() & $urandom() & $urandom();
    run_strings(words, 60, -1);

    // One long string at full rate, every byte expanded, no idling on either side
    foreach (words[k]) words[k] = '1;
    load_masks(words);
    idle_on = 1'b0;
    for (int i = 0; i < RUN_BEATS; i++) begin
      send_beat(pick_byte(), 1'b0, 0, 24'h0);
    end
    send_beat(pick_byte(), 1'b1, 0, 24'h0);
    idle_on = 1'b1;
    // the count must restart after the long string
    for (int i = 0; i < 12; i++) begin
      send_beat(pick_byte(), $urandom_range(3) == 0, 0, 24'h0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d strings under %0d random-phase mask settings,",
             beats_sent, strings_sent, mask_settings);
    $display("checked %0d output beats, %0d faults.", beats_checked, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- url_percent_encoder.f -----
rtl/urlpe_pkg.sv
rtl/urlpe_if.sv
rtl/urlpe_mask.sv
rtl/url_percent_encoder.sv
verif/testbench.sv
